@@ hdl/ccl_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ccl_pkg: shared types and constants of the CSV cell locator
// Character codes, end status codes and the record that travels from the
// scanner through the result queue to the output sequencer.
// ============================================================================
package ccl_pkg;

    localparam int REG_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_ROW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_COLUMN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE_CHAR    = 2'd2;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] QUOTE_RESET = 8'd39;

    localparam logic [1:0] ST_FOUND  = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_UNTERM = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Everything one text byte produces: an optional data byte, then an
    // optional end status.
    typedef struct packed {
        logic       has_data;
        logic [7:0] data;
        logic       has_status;
        logic [1:0] status;
    } rec_t;

endpackage

@@ hdl/csv_cell_locator_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// csv_cell_locator_unit: CSV cell locator
// Scans CSV text one byte per transfer, streams the bytes of the cell at the
// configured row and column and closes with an end status.
// ============================================================================
// Path: each result is registered in the result queue before it is offered.
// Throughput: one byte per cycle while the result queue has room. A byte that
// yields a data byte and an end status becomes two output transfers, absorbed
// by the four-entry result queue; the scanner settles bytes combinationally.
// Reset: asynchronous, active low; clears scan state and the queue and loads
// the register defaults (row 0, column 0, quote character 39).
module csv_cell_locator_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [ccl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ccl_pkg::REG_W-1:0]       cfg_data,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     text_byte,
    input  logic                           end_of_text,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           result_kind,
    output logic [7:0]                     cell_byte,
    output logic [1:0]                     cell_status,
    output logic                           last_result
);
    import ccl_pkg::*;

    logic [REG_W-1:0] target_row_reg;
    logic [REG_W-1:0] target_column_reg;
    logic [7:0]       quote_char_reg;

    logic in_xfer;
    logic queue_full;
    logic queue_not_empty;
    logic queue_pop;
    rec_t front_rec;
    rec_t head_rec;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_row_reg    <= '0;
            target_column_reg <= '0;
            quote_char_reg    <= QUOTE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET_ROW:    target_row_reg    <= cfg_data;
                CFG_TARGET_COLUMN: target_column_reg <= cfg_data;
                CFG_QUOTE_CHAR:    quote_char_reg    <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // Stall input only when the queue has no room for another record.
    assign in_stall = queue_full;
    assign in_xfer  = in_valid && !queue_full;

    ccl_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_xfer),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .target_row   (target_row_reg),
        .target_column(target_column_reg),
        .quote_char   (quote_char_reg),
        .rec          (front_rec)
    );

    // Push only records that carry at least one result.
    ccl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_xfer && (front_rec.has_data || front_rec.has_status)),
        .push_rec (front_rec),
        .pop      (queue_pop),
        .full     (queue_full),
        .not_empty(queue_not_empty),
        .head_rec (head_rec)
    );

    ccl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (queue_not_empty),
        .head_rec   (head_rec),
        .pop        (queue_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_kind(result_kind),
        .cell_byte  (cell_byte),
        .cell_status(cell_status),
        .last_result(last_result)
    );

endmodule

@@ hdl/ccl_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ccl_front: byte scanner
// Tracks quotes, columns and rows, locates the target cell and classifies
// each transferred byte into a result record.
// ============================================================================
module ccl_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [7:0]               text_byte,
    input  logic                     end_of_text,
    input  logic [ccl_pkg::REG_W-1:0] target_row,
    input  logic [ccl_pkg::REG_W-1:0] target_column,
    input  logic [7:0]               quote_char,
    output ccl_pkg::rec_t            rec
);
    import ccl_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;

    localparam logic [1:0] PH_SEEK = 2'd0;
    localparam logic [1:0] PH_SKIP = 2'd1;
    localparam logic [1:0] PH_CELL = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [COUNT_WIDTH-1:0] row_reg, row_next;
    logic [COUNT_WIDTH-1:0] col_reg, col_next;
    logic                   inq_reg, inq_next;
    logic [1:0]             phase_reg, phase_next;
    logic                   quoted_reg, quoted_next;
    logic                   hasb_reg, hasb_next;

    logic go;
    logic reached;
    logic is_quote;
    logic is_break;
    logic is_pad;
    logic ends_text;

    always_comb
    begin
        is_quote  = (text_byte == quote_char);
        is_break  = (text_byte == CHAR_CR) || (text_byte == CHAR_LF);
        is_pad    = (text_byte == CHAR_SPACE) || (text_byte == CHAR_TAB);
        ends_text = (text_byte == CHAR_NUL) || end_of_text;
        reached   = (CMP_W'(row_reg) >= CMP_W'(target_row))
                 && (CMP_W'(col_reg) >= CMP_W'(target_column));

        row_next    = row_reg;
        col_next    = col_reg;
        inq_next    = inq_reg;
        phase_next  = phase_reg;
        quoted_next = quoted_reg;
        hasb_next   = hasb_reg;
        rec         = '0;
        go          = (text_byte != CHAR_NUL);

        if (go && phase_next == PH_SEEK)
        begin
            if (!reached)
            begin
                if (is_quote)
                    inq_next = !inq_reg;
                else if (!inq_reg && text_byte == CHAR_COMMA)
                begin
                    if (col_reg != '1)
                        col_next = col_reg + 1'b1;
                end
                else if (!inq_reg && is_break)
                begin
                    col_next = '0;
                    if (row_reg != '1)
                        row_next = row_reg + 1'b1;
                end
                go = 1'b0;
            end
            else
                phase_next = PH_SKIP;
        end

        if (go && phase_next == PH_SKIP)
        begin
            if (is_pad)
                go = 1'b0;
            else if (is_quote)
            begin
                quoted_next = 1'b1;
                phase_next  = PH_CELL;
                go          = 1'b0;
            end
            else
                phase_next = PH_CELL;
        end

        if (go && phase_next == PH_CELL)
        begin
            if (quoted_next && is_quote)
            begin
                phase_next     = PH_DONE;
                rec.has_status = 1'b1;
                rec.status     = hasb_next ? ST_FOUND : ST_EMPTY;
            end
            else if (quoted_next && is_break)
            begin
                phase_next     = PH_DONE;
                rec.has_status = 1'b1;
                rec.status     = ST_UNTERM;
            end
            else if (!quoted_next && (is_break || text_byte == CHAR_COMMA))
            begin
                phase_next     = PH_DONE;
                rec.has_status = 1'b1;
                rec.status     = hasb_next ? ST_FOUND : ST_EMPTY;
            end
            else
            begin
                hasb_next    = 1'b1;
                rec.has_data = 1'b1;
                rec.data     = text_byte;
            end
        end

        // End of text: report if nothing was reported yet, then start over.
        if (ends_text)
        begin
            if (phase_next != PH_DONE)
            begin
                rec.has_status = 1'b1;
                if (phase_next == PH_CELL && quoted_next)
                    rec.status = ST_UNTERM;
                else if (phase_next == PH_CELL && hasb_next)
                    rec.status = ST_FOUND;
                else
                    rec.status = ST_EMPTY;
            end
            row_next    = '0;
            col_next    = '0;
            inq_next    = 1'b0;
            phase_next  = PH_SEEK;
            quoted_next = 1'b0;
            hasb_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            col_reg    <= '0;
            inq_reg    <= 1'b0;
            phase_reg  <= PH_SEEK;
            quoted_reg <= 1'b0;
            hasb_reg   <= 1'b0;
        end
        else if (accept)
        begin
            row_reg    <= row_next;
            col_reg    <= col_next;
            inq_reg    <= inq_next;
            phase_reg  <= phase_next;
            quoted_reg <= quoted_next;
            hasb_reg   <= hasb_next;
        end
    end

endmodule

@@ hdl/ccl_queue.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ccl_queue: result record queue
// Short FIFO that decouples the scanner from the output sequencer.
// ============================================================================
module ccl_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ccl_pkg::rec_t push_rec,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output ccl_pkg::rec_t head_rec
);
    import ccl_pkg::*;

    rec_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        full      = (fill_reg == FILL_W'(QUEUE_DEPTH));
        not_empty = (fill_reg != '0);
        head_rec  = entry_reg[rd_ptr_reg];
        do_push   = push && !full;
        do_pop    = pop && not_empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

@@ hdl/ccl_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ccl_back: output sequencer
// Presents the head record as one or two result transfers, data byte first.
// ============================================================================
module ccl_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  ccl_pkg::rec_t head_rec,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          result_kind,
    output logic [7:0]    cell_byte,
    output logic [1:0]    cell_status,
    output logic          last_result
);
    import ccl_pkg::*;

    logic data_done_reg, data_done_next;
    logic show_data;
    logic xfer;

    always_comb
    begin
        show_data = head_rec.has_data && !data_done_reg;
        out_valid = head_valid;
        xfer      = head_valid && !out_stall;

        result_kind = show_data ? KIND_DATA : KIND_STATUS;
        cell_byte   = show_data ? head_rec.data : 8'h00;
        cell_status = show_data ? ST_FOUND : head_rec.status;
        last_result = !show_data;

        // Hold the record after its data byte when a status still follows.
        pop            = 1'b0;
        data_done_next = data_done_reg;
        if (xfer)
        begin
            if (show_data && head_rec.has_status)
                data_done_next = 1'b1;
            else
            begin
                pop            = 1'b1;
                data_done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_done_reg <= 1'b0;
        else
            data_done_reg <= data_done_next;
    end

endmodule
